>>> rtl/fbma_pkg.sv
package fbma_pkg;

    localparam int DIRECT_SLOTS   = 12;
    localparam int INDIRECT_SLOTS = 128;
    localparam int BLOCK_BYTES    = 512;

    localparam int OFS_W   = 17;
    localparam int BLK_W   = 32;
    localparam int TAKEN_W = 2;

    localparam int TOTAL_SLOTS = DIRECT_SLOTS + INDIRECT_SLOTS;
    localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
    localparam int BLK_SH      = $clog2(BLOCK_BYTES);

    // first byte offset past the largest file
    localparam logic [31:0] OFS_LIMIT = 32'(TOTAL_SLOTS * BLOCK_BYTES);

    // stream widths, rounded up to whole bytes
    localparam int IN_W  = ((OFS_W + 2 * BLK_W + 7) / 8) * 8;
    localparam int OUT_W = ((BLK_W + TAKEN_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOOKUP = 2'b10
    } t_state;

endpackage

>>> rtl/file_block_map_with_allocation_core.sv
// Channel   | Dir | Payload (lowest bit first)
// ----------+-----+-----------------------------------------------------------
// s_axis    | in  | tdata: byte_offset[16:0], fresh_block_first[31:0],
//           |     |        fresh_block_second[31:0], zero fill to 88 bits
// m_axis    | out | tdata: disk_block[31:0], blocks_taken[1:0], zero fill
//           |     | tuser: range_error
//
// Each item runs in order: the accept edge reads the pointer memory into a
// register, then the lookup state resolves the miss, writes the memory and loads
// the output register. Items do not overlap: a new one is taken only back in the
// idle state.
// Reset clears the valid bits of every pointer and the indirect block pointer
// at once, so the file is empty right after reset; no clearing pass.
// A result waiting on m_axis holds the lookup stage, and s_axis stays low then.
module file_block_map_with_allocation_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // byte_offset, fresh_block_first, fresh_block_second
    input  logic [fbma_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // disk_block, blocks_taken
    output logic [fbma_pkg::OUT_W-1:0]  m_axis_tdata,
    // range_error
    output logic                        m_axis_tuser
);
    import fbma_pkg::*;

    // Direct pointers sit at slots below DIRECT_SLOTS, indirect ones above.
    logic [BLK_W-1:0]        r_mem [TOTAL_SLOTS];
    logic [TOTAL_SLOTS-1:0]  r_valid;
    logic [BLK_W-1:0]        r_rd_data;
    logic                    r_rd_valid;

    t_state                  r_state, n_state;
    logic [BLK_W-1:0]        r_ind_blk, n_ind_blk;
    logic [SLOT_W-1:0]       r_slot;
    logic                    r_range_err;
    logic [BLK_W-1:0]        r_fresh1, r_fresh2;

    logic                    r_out_valid;
    logic [BLK_W-1:0]        r_out_blk, n_out_blk;
    logic [TAKEN_W-1:0]      r_out_taken, n_out_taken;
    logic                    r_out_err;

    logic [OFS_W-1:0]        w_off;
    logic [OFS_W-1:0]        w_idx_full;
    logic [SLOT_W-1:0]       w_idx;
    logic                    w_in_range;
    logic                    w_accept;
    logic                    w_done;
    logic [BLK_W-1:0]        w_ptr;
    logic                    w_ind_miss;
    logic                    w_we;
    logic [BLK_W-1:0]        w_wdata;

    assign w_off      = s_axis_tdata[OFS_W-1:0];
    assign w_idx_full = w_off >> BLK_SH;
    assign w_idx      = w_idx_full[SLOT_W-1:0];
    assign w_in_range = 32'(w_off) < OFS_LIMIT;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_done        = (r_state == S_LOOKUP) && (!r_out_valid || m_axis_tready);

    // An entry never written reads as unallocated.
    assign w_ptr      = r_rd_valid ? r_rd_data : '0;
    assign w_ind_miss = (r_ind_blk == '0);

    // Resolve the miss and pick the write-back.
    always_comb begin
        n_ind_blk   = r_ind_blk;
        n_out_blk   = w_ptr;
        n_out_taken = '0;
        w_we        = 1'b0;
        w_wdata     = r_fresh1;
        if (!r_range_err) begin
            if (32'(r_slot) < 32'(DIRECT_SLOTS)) begin
                if (w_ptr == '0) begin
                    w_we        = 1'b1;
                    w_wdata     = r_fresh1;
                    n_out_taken = TAKEN_W'(1);
                end
            end else begin
                if (w_ind_miss) begin
                    n_ind_blk = r_fresh1;
                end
                if (w_ptr == '0) begin
                    w_we        = 1'b1;
                    w_wdata     = w_ind_miss ? r_fresh2 : r_fresh1;
                    n_out_taken = TAKEN_W'({1'b0, w_ind_miss}) + TAKEN_W'(1);
                end else begin
                    n_out_taken = TAKEN_W'({1'b0, w_ind_miss});
                end
            end
            if (w_we) begin
                n_out_blk = w_wdata;
            end
        end else begin
            n_out_blk = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_LOOKUP;
            S_LOOKUP: if (w_done) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Pointer memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_done && w_we) begin
            r_mem[r_slot] <= w_wdata;
        end
        if (w_accept && w_in_range) begin
            r_rd_data <= r_mem[w_idx];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_ind_blk   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_done) begin
                r_ind_blk   <= n_ind_blk;
                r_out_valid <= 1'b1;
                if (w_we) begin
                    r_valid[r_slot] <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload captured at accept and at completion.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_slot      <= w_in_range ? w_idx : '0;
            r_range_err <= !w_in_range;
            r_rd_valid  <= w_in_range && r_valid[w_idx];
            r_fresh1    <= s_axis_tdata[OFS_W +: BLK_W];
            r_fresh2    <= s_axis_tdata[OFS_W + BLK_W +: BLK_W];
        end
        if (w_done) begin
            r_out_blk   <= n_out_blk;
            r_out_taken <= n_out_taken;
            r_out_err   <= r_range_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_taken, r_out_blk});
    assign m_axis_tuser  = r_out_err;

endmodule
